// ===== src/i2cmws_pkg.sv =====
// shared types and codes for the i2c master write sequencer
`timescale 1ns / 1ps

package i2cmws_pkg;

  // command codes
  localparam logic CMD_QUEUE  = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  // bus actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;
  localparam logic [2:0] ACT_RESET   = 3'd5;

  // bus status codes after masking
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_RD_NACK   = 8'h48;

  // result word leaving the decode stage
  typedef struct packed {
    logic       accepted;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       busy_res;
    logic       from_mem;
  } res_t;

  // fifo memory strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== src/i2cmws_top.sv =====
// top level of the i2c master write sequencer
`timescale 1ns / 1ps

// channel   | handshake           | fields
// ----------+---------------------+------------------------------------------------
// input     | in_valid / in_ready | command target_address data_byte last_byte status_code
// result    | out_valid/out_ready | accepted action tx_byte busy_res
//
// one word per cycle while the result side is ready; each word leaves through the
// fifo read stage, then the output register, as the fifo memory read is registered.
// reset clears pointers, fill count, busy and stored address; fifo contents are
// left as they are. a stalled result holds the output register while one more
// word can still be taken into the read stage.

module i2c_master_write_sequencer_top
  import i2cmws_pkg::*;
#(
  parameter int FIFO_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [6:0] target_address,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] status_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] action,
  output logic [7:0] tx_byte,
  output logic       busy_res
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic          fire;
  res_t          res;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [7:0]    rd_data;

  assign fire = in_valid && in_ready;

  // decode and fifo bookkeeping
  i2cmws_ctrl #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .command        (command),
    .target_address (target_address),
    .last_byte      (last_byte),
    .status_code    (status_code),
    .res            (res),
    .mem_ctl        (mem_ctl),
    .wr_ptr         (wr_ptr),
    .rd_ptr         (rd_ptr)
  );

  // transmit fifo storage
  i2cmws_mem #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (wr_ptr),
    .wr_data (data_byte),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // result pipe
  i2cmws_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .res        (res),
    .rd_data    (rd_data),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted),
    .action     (action),
    .tx_byte    (tx_byte),
    .busy_res   (busy_res)
  );

endmodule

// ===== src/i2cmws_mem.sv =====
// transmit fifo storage, one write and one registered read port
`timescale 1ns / 1ps

module i2cmws_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] store [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

// ===== src/i2cmws_ctrl.sv =====
// fifo pointers, busy flag and bus status decode
`timescale 1ns / 1ps

module i2cmws_ctrl
  import i2cmws_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int CW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          command,
  input  logic [6:0]    target_address,
  input  logic          last_byte,
  input  logic [7:0]    status_code,
  output res_t          res,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] wr_ptr,
  output logic [AW-1:0] rd_ptr
);

  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          busy;
  logic          busy_next;
  logic [6:0]    addr;
  logic [6:0]    addr_next;
  logic [7:0]    status_m;
  mem_ctl_t      mem_req;

  assign status_m = status_code & STATUS_MASK;

  // decode one word and work out the next control state
  always_comb begin
    wr_ptr_next  = wr_ptr;
    rd_ptr_next  = rd_ptr;
    count_next   = count;
    busy_next    = busy;
    addr_next    = addr;
    mem_req      = '0;
    res          = '0;
    res.action   = ACT_NONE;
    if (command == CMD_QUEUE) begin
      if (!busy && count != COUNT_FULL) begin
        mem_req.wr_en = 1'b1;
        wr_ptr_next   = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
        count_next    = count + CW'(1);
        addr_next     = target_address;
        res.accepted  = 1'b1;
        if (last_byte) begin
          busy_next  = 1'b1;
          res.action = ACT_START;
        end
      end
    end else begin
      case (status_m)
        ST_START, ST_RSTART: begin
          res.action  = ACT_SEND;
          res.tx_byte = {addr, 1'b0};
        end
        ST_ADDR_ACK, ST_DATA_ACK: begin
          if (count == '0) begin
            res.action = ACT_STOP;
            busy_next  = 1'b0;
          end else begin
            res.action    = ACT_SEND;
            res.from_mem  = 1'b1;
            mem_req.rd_en = 1'b1;
            rd_ptr_next   = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
            count_next    = count - CW'(1);
          end
        end
        ST_ADDR_NACK, ST_DATA_NACK, ST_RD_NACK: begin
          res.action = ACT_STOP;
          busy_next  = 1'b0;
        end
        ST_ARB_LOST: begin
          res.action = ACT_RELEASE;
          busy_next  = 1'b0;
        end
        ST_BUS_ERROR: begin
          res.action = ACT_RESET;
          busy_next  = 1'b0;
        end
        default: begin
        end
      endcase
    end
    res.busy_res = busy_next;
  end

  // memory strobes only on a word taken by the input handshake
  assign mem_ctl.wr_en = mem_req.wr_en & fire;
  assign mem_ctl.rd_en = mem_req.rd_en & fire;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      busy   <= 1'b0;
      addr   <= '0;
    end else if (fire) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      busy   <= busy_next;
      addr   <= addr_next;
    end
  end

`ifndef SYNTHESIS
  // fill level stays within the fifo
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("fifo fill count beyond depth");

  // a read never hits an empty fifo
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.rd_en |-> count != '0)
    else $error("fifo read while empty");

  // a write moves the write pointer and raises the count by one
  a_wr_count: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |=> count == $past(count) + CW'(1))
    else $error("fill count did not follow a write");
`endif

endmodule

// ===== src/i2cmws_outq.sv =====
// two-deep result pipe: memory read stage and output register
`timescale 1ns / 1ps

module i2cmws_outq
  import i2cmws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       res,
  input  logic [7:0] rd_data,
  output logic       load_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] action,
  output logic [7:0] tx_byte,
  output logic       busy_res
);

  logic s1_valid;
  res_t s1_res;
  logic s1_move;

  assign s1_move    = s1_valid && (!out_valid || out_ready);
  assign load_ready = !s1_valid || s1_move;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, fifo byte merged as the word leaves the read stage
  always_ff @(posedge clk) begin
    if (load) begin
      s1_res <= res;
    end
    if (s1_move) begin
      accepted <= s1_res.accepted;
      action   <= s1_res.action;
      tx_byte  <= s1_res.from_mem ? rd_data : s1_res.tx_byte;
      busy_res <= s1_res.busy_res;
    end
  end

`ifndef SYNTHESIS
  // read stage is never overwritten while it still holds a word
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load && s1_valid |-> s1_move)
    else $error("read stage overwritten");
`endif

endmodule

// ===== dv/tb_i2c_master_write_sequencer_top.sv =====
// self-checking testbench for the i2c master write sequencer
`timescale 1ns / 1ps

module tb_i2c_master_write_sequencer_top;
  import i2cmws_pkg::*;

  localparam int FIFO_DEPTH    = 32;
  localparam int RANDOM_WORDS  = 1300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  // one input word as driven on the ports
  typedef struct {
    logic       cmd;
    logic [6:0] addr;
    logic [7:0] data;
    logic       last;
    logic [7:0] status;
  } in_word_t;

  // one result word as seen on the ports
  typedef struct {
    logic       acc;
    logic [2:0] act;
    logic [7:0] tx;
    logic       busy;
  } bus_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = 1'b0;
  logic [6:0] target_address = '0;
  logic [7:0] data_byte = '0;
  logic       last_byte = 1'b0;
  logic [7:0] status_code = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       busy_res;

  in_word_t    pending_words[$];
  bus_result_t bus_result_q[$];
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // shadow of the sequencer state
  logic [7:0] tx_fifo [FIFO_DEPTH];
  int         rd_ptr = 0;
  int         wr_ptr = 0;
  int         fill_cnt = 0;
  logic       busy_st = 1'b0;
  logic [6:0] addr_st = '0;

  i2c_master_write_sequencer_top #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .target_address(target_address),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .status_code(status_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .action(action),
    .tx_byte(tx_byte),
    .busy_res(busy_res)
  );

  always #5 clk = ~clk;

  // next bus action for one accepted word, updating the shadow state
  function automatic bus_result_t predict_bus_action(in_word_t w);
    bus_result_t r;
    logic [7:0]  st;
    r.acc  = 1'b0;
    r.act  = ACT_NONE;
    r.tx   = 8'h00;
    st     = w.status & STATUS_MASK;
    if (w.cmd == CMD_QUEUE) begin
      if (!busy_st && fill_cnt < FIFO_DEPTH) begin
        tx_fifo[wr_ptr] = w.data;
        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
        fill_cnt++;
        addr_st = w.addr;
        r.acc = 1'b1;
        if (w.last) begin
          busy_st = 1'b1;
          r.act = ACT_START;
        end
      end
    end else begin
      case (st)
        ST_START, ST_RSTART: begin
          r.act = ACT_SEND;
          r.tx  = {addr_st, 1'b0};
        end
        ST_ADDR_ACK, ST_DATA_ACK: begin
          if (fill_cnt == 0) begin
            r.act = ACT_STOP;
            busy_st = 1'b0;
          end else begin
            r.act = ACT_SEND;
            r.tx  = tx_fifo[rd_ptr];
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            fill_cnt--;
          end
        end
        ST_ADDR_NACK, ST_DATA_NACK, ST_RD_NACK: begin
          r.act = ACT_STOP;
          busy_st = 1'b0;
        end
        ST_ARB_LOST: begin
          r.act = ACT_RELEASE;
          busy_st = 1'b0;
        end
        ST_BUS_ERROR: begin
          r.act = ACT_RESET;
          busy_st = 1'b0;
        end
        default: ;
      endcase
    end
    r.busy = busy_st;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < PRINT_LIMIT) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  // input driver: holds each word until taken, then idles a drawn number of cycles
  in_word_t nxt_word;
  int       in_gap = 0;
  logic     in_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_words.size() != 0) begin
        nxt_word = pending_words.pop_front();
        command        <= nxt_word.cmd;
        target_address <= nxt_word.addr;
        data_byte      <= nxt_word.data;
        last_byte      <= nxt_word.last;
        status_code    <= nxt_word.status;
        in_valid       <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks each result word, then records the prediction for
  // the input word taken at this edge
  bus_result_t exp_res;
  bus_result_t new_res;
  in_word_t    taken_word;
  int          out_stall = 0;
  int          out_draw;
  logic        out_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_result_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          exp_res = bus_result_q.pop_front();
          if (accepted !== exp_res.acc)
            report_mismatch($sformatf("accepted got %0b exp %0b", accepted, exp_res.acc));
          if (action !== exp_res.act)
            report_mismatch($sformatf("action got %0d exp %0d", action, exp_res.act));
          if (tx_byte !== exp_res.tx)
            report_mismatch($sformatf("tx_byte got %02h exp %02h", tx_byte, exp_res.tx));
          if (busy_res !== exp_res.busy)
            report_mismatch($sformatf("busy_res got %0b exp %0b", busy_res, exp_res.busy));
        end
        if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
        out_draw = out_calm ? 0 : $urandom_range(0, 6);
        out_stall <= out_draw;
        out_ready <= (out_draw == 0);
      end else if (!out_ready) begin
        if (out_stall <= 1) begin
          out_ready <= 1'b1;
          out_stall <= 0;
        end else begin
          out_stall <= out_stall - 1;
        end
      end
      if (in_valid && in_ready) begin
        taken_word.cmd    = command;
        taken_word.addr   = target_address;
        taken_word.data   = data_byte;
        taken_word.last   = last_byte;
        taken_word.status = status_code;
        new_res = predict_bus_action(taken_word);
        bus_result_q.push_back(new_res);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus builders
  task automatic queue_byte(logic [6:0] a, logic [7:0] d, logic l);
    in_word_t w;
    w.cmd    = CMD_QUEUE;
    w.addr   = a;
    w.data   = d;
    w.last   = l;
    w.status = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
  endtask

  // status event with random don't-care low bits
  task automatic bus_event(logic [7:0] code);
    in_word_t w;
    w.cmd    = CMD_STATUS;
    w.addr   = 7'($urandom_range(0, 127));
    w.data   = 8'($urandom_range(0, 255));
    w.last   = 1'($urandom_range(0, 1));
    w.status = {code[7:3], 3'($urandom_range(0, 7))};
    pending_words.push_back(w);
  endtask

  task automatic exact_event(logic [7:0] st);
    in_word_t w;
    w.cmd    = CMD_STATUS;
    w.addr   = '0;
    w.data   = '0;
    w.last   = 1'b0;
    w.status = st;
    pending_words.push_back(w);
  endtask

  function automatic logic [7:0] abort_code();
    case ($urandom_range(0, 4))
      0: return ST_ADDR_NACK;
      1: return ST_DATA_NACK;
      2: return ST_RD_NACK;
      3: return ST_ARB_LOST;
      default: return ST_BUS_ERROR;
    endcase
  endfunction

  // well-formed write: queue bytes, start, address ack, data acks, maybe cut short
  task automatic write_sequence();
    int         n;
    int         cut;
    logic [6:0] a;
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    a   = 7'($urandom_range(0, 127));
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) queue_byte(a, 8'($urandom_range(0, 255)), i == n - 1);
    if ($urandom_range(0, 7) == 0) queue_byte(a, 8'($urandom_range(0, 255)), 1'b1);
    bus_event($urandom_range(0, 1) ? ST_START : ST_RSTART);
    for (int k = 0; k <= n; k++) begin
      if (k == cut) begin
        bus_event(abort_code());
        break;
      end
      bus_event(k == 0 ? ST_ADDR_ACK : ST_DATA_ACK);
    end
    if (cut < 0) begin
      repeat ($urandom_range(0, 2)) bus_event(ST_DATA_ACK);
    end
  endtask

  // overfill the fifo, then drain it
  task automatic fill_and_drain();
    logic [6:0] a;
    a = 7'($urandom_range(0, 127));
    repeat (FIFO_DEPTH + 2) queue_byte(a, 8'($urandom_range(0, 255)), 1'b0);
    queue_byte(a, 8'($urandom_range(0, 255)), 1'b1);
    bus_event(ST_START);
    repeat (FIFO_DEPTH + 3) bus_event(ST_DATA_ACK);
  endtask

  // main sequence
  int pick;
  initial begin
    // directed words
    exact_event(ST_START);                // start event while idle
    queue_byte(7'h7F, 8'hFF, 1'b0);       // accepted, not last
    queue_byte(7'h00, 8'h00, 1'b1);       // launches the write
    queue_byte(7'h55, 8'hAA, 1'b1);       // rejected while busy
    exact_event(8'h0F);                   // start, low bits set
    exact_event(ST_ADDR_ACK);
    exact_event(8'h2F);                   // data ack, low bits set
    exact_event(ST_DATA_ACK);             // fifo empty: stop
    queue_byte(7'h7F, 8'h80, 1'b1);
    exact_event(ST_RSTART);
    exact_event(ST_ADDR_NACK);            // nack leaves the byte queued
    queue_byte(7'h01, 8'h7F, 1'b1);
    exact_event(ST_DATA_NACK);
    exact_event(ST_RD_NACK);
    exact_event(ST_ARB_LOST);
    exact_event(ST_BUS_ERROR);
    exact_event(8'h07);                   // bus error, low bits set
    exact_event(8'h50);                   // unknown code
    exact_event(8'hFF);
    exact_event(ST_DATA_ACK);             // acks while idle drain leftovers
    exact_event(ST_ADDR_ACK);
    exact_event(ST_ADDR_ACK);
    // random part
    while (pending_words.size() < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        write_sequence();
      end else if (pick < 99) begin
        if ($urandom_range(0, 1)) begin
          queue_byte(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end else begin
          exact_event(8'($urandom_range(0, 255)));
        end
      end else begin
        fill_and_drain();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // sample between edges so the driver's updates have settled
    while (pending_words.size() != 0 || in_valid || bus_result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && bus_result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
